@@ hw/rtl/tgp_pkg.sv @@
// tgp_pkg: word types and shared constants for the triangle geometry predicates block
// no dependencies; imported by tgp_div, triangle_geometry_predicates_top and the testbench
`timescale 1ns / 1ps

package tgp_pkg;

  localparam int COORD_BITS_DEF = 16;
  localparam int FRAC_BITS_DEF  = 8;
  // quotient bits resolved by the divider, one per step
  localparam int QUO_BITS       = 32;

  typedef struct packed {
    logic signed [15:0] a_x;
    logic signed [15:0] a_y;
    logic signed [15:0] b_x;
    logic signed [15:0] b_y;
    logic signed [15:0] c_x;
    logic signed [15:0] c_y;
    logic signed [15:0] test_x;
    logic signed [15:0] test_y;
  } in_word_t;

  typedef struct packed {
    logic signed [33:0] area_twice;
    logic               inside_triangle;
    logic               inside_circle;
    logic signed [31:0] center_x;
    logic signed [31:0] center_y;
    logic               center_valid;
    logic               center_saturated;
  } out_word_t;

endpackage

@@ hw/rtl/tgp_div.sv @@
// tgp_div: pipelined restoring divider, one quotient bit per stage plus an overflow check stage
// depends on tgp_pkg (QUO_BITS)
`timescale 1ns / 1ps

module tgp_div import tgp_pkg::*; #(
  parameter int RW  = 67,
  parameter int DDW = 36
) (
  input  logic                clk,
  input  logic [QUO_BITS:0]   adv,
  input  logic [RW-1:0]       num,
  input  logic [DDW-1:0]      den,
  output logic [QUO_BITS-1:0] quo,
  output logic                ovf
);

  logic [RW-1:0]       rem_r   [0:QUO_BITS];
  logic [RW-1:0]       rem_nxt [0:QUO_BITS];
  logic [DDW-1:0]      den_r   [0:QUO_BITS];
  logic [QUO_BITS-1:0] q_r     [0:QUO_BITS];
  logic [QUO_BITS-1:0] q_nxt   [0:QUO_BITS];
  logic                ovf_r   [0:QUO_BITS];
  logic                ovf_nxt;

  always_comb begin
    logic [RW-1:0] sh;
    logic          ge;
    // quotient would need more than QUO_BITS bits
    ovf_nxt    = num >= (RW'(den) << QUO_BITS);
    rem_nxt[0] = num;
    q_nxt[0]   = '0;
    for (int j = 1; j <= QUO_BITS; j++) begin
      sh         = RW'(den_r[j-1]) << (QUO_BITS - j);
      ge         = rem_r[j-1] >= sh;
      rem_nxt[j] = ge ? rem_r[j-1] - sh : rem_r[j-1];
      q_nxt[j]   = {q_r[j-1][QUO_BITS-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      rem_r[0] <= rem_nxt[0];
      den_r[0] <= den;
      q_r[0]   <= q_nxt[0];
      ovf_r[0] <= ovf_nxt;
    end
    for (int j = 1; j <= QUO_BITS; j++) begin
      if (adv[j]) begin
        rem_r[j] <= rem_nxt[j];
        den_r[j] <= den_r[j-1];
        q_r[j]   <= q_nxt[j];
        ovf_r[j] <= ovf_r[j-1];
      end
    end
  end

  assign quo = q_r[QUO_BITS];
  assign ovf = ovf_r[QUO_BITS];

endmodule

@@ hw/rtl/triangle_geometry_predicates_top.sv @@
// triangle_geometry_predicates_top: exact area, containment, in-circle and circumcenter
// depends on tgp_pkg and tgp_div
`timescale 1ns / 1ps

// One query word in, one result word out. The pipeline has six arithmetic stages, an
// overflow check and one stage per quotient bit in the two circumcenter dividers, and
// the output register. A new word is taken every cycle while in_stall is low; a
// stall on the output only backs up the pipeline as far as its empty stages allow, and
// in_stall rises only when every stage holds a word. All arithmetic is exact integer.
module triangle_geometry_predicates_top import tgp_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_word,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_word
);

  localparam int CB    = COORD_BITS;
  localparam int D     = CB + 1;             // coordinate differences
  localparam int P     = 2 * D;              // first products
  localparam int Q     = P + 1;              // sums of two products
  localparam int MW    = 2 * Q;              // lifted-determinant terms
  localparam int DW    = MW + 2;             // lifted determinant
  localparam int NPW   = Q + D;              // center numerator terms
  localparam int NW    = NPW + 3;            // center numerators
  localparam int DDW   = Q + 1;              // divisor magnitude
  localparam int MSW   = NW + FRAC_BITS;     // scaled numerator magnitude
  localparam int RW    = (MSW > DDW + QUO_BITS) ? MSW : DDW + QUO_BITS;
  localparam int AXW   = (Q > 34) ? Q : 34;
  localparam int DIV0  = 6;
  localparam int NPIPE = DIV0 + QUO_BITS + 2;

  localparam logic signed [AXW-1:0] AMAX = AXW'(64'sh1_FFFF_FFFF);
  localparam logic signed [AXW-1:0] AMIN = AXW'(-64'sh2_0000_0000);
  localparam logic [QUO_BITS-1:0] LIM_POS = {1'b0, {(QUO_BITS-1){1'b1}}};
  localparam logic [QUO_BITS-1:0] LIM_NEG = {1'b1, {(QUO_BITS-1){1'b0}}};

  typedef struct packed {
    logic signed [33:0] area;
    logic               in_tri;
    logic               in_circ;
    logic               zero;
    logic               neg_x;
    logic               neg_y;
  } side_t;

  // pipeline control
  logic [NPIPE-1:0] v_r;
  logic [NPIPE-1:0] adv;

  always_comb begin
    adv[NPIPE-1] = !v_r[NPIPE-1] || !out_stall;
    for (int k = NPIPE - 2; k >= 0; k--) begin
      adv[k] = !v_r[k] || adv[k+1];
    end
  end

  assign in_stall  = !adv[0];
  assign out_valid = v_r[NPIPE-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (adv[0]) begin
        v_r[0] <= in_valid;
      end
      for (int k = 1; k < NPIPE; k++) begin
        if (adv[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  // stage 0: coordinates and differences
  logic signed [CB-1:0] ax, ay, bx, by, cx, cy, tx, ty;
  logic signed [CB-1:0] ax_r, ay_r, bx_r, by_r, cx_r, cy_r;
  logic signed [D-1:0]  bax_r, bay_r, cax_r, cay_r, cbx_r, cby_r, acx_r, acy_r;
  logic signed [D-1:0]  adx_r, ady_r, bdx_r, bdy_r, cdx_r, cdy_r;

  assign ax = CB'(in_word.a_x);
  assign ay = CB'(in_word.a_y);
  assign bx = CB'(in_word.b_x);
  assign by = CB'(in_word.b_y);
  assign cx = CB'(in_word.c_x);
  assign cy = CB'(in_word.c_y);
  assign tx = CB'(in_word.test_x);
  assign ty = CB'(in_word.test_y);

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      ax_r  <= ax;
      ay_r  <= ay;
      bx_r  <= bx;
      by_r  <= by;
      cx_r  <= cx;
      cy_r  <= cy;
      bax_r <= D'(bx) - D'(ax);
      bay_r <= D'(by) - D'(ay);
      cax_r <= D'(cx) - D'(ax);
      cay_r <= D'(cy) - D'(ay);
      cbx_r <= D'(cx) - D'(bx);
      cby_r <= D'(cy) - D'(by);
      acx_r <= D'(ax) - D'(cx);
      acy_r <= D'(ay) - D'(cy);
      adx_r <= D'(ax) - D'(tx);
      ady_r <= D'(ay) - D'(ty);
      bdx_r <= D'(bx) - D'(tx);
      bdy_r <= D'(by) - D'(ty);
      cdx_r <= D'(cx) - D'(tx);
      cdy_r <= D'(cy) - D'(ty);
    end
  end

  // stage 1: products
  logic signed [P-1:0] ps0_r, ps1_r, p11_r, p12_r, p21_r, p22_r, p31_r, p32_r;
  logic signed [P-1:0] qax_r, qay_r, qbx_r, qby_r, qcx_r, qcy_r;
  logic signed [P-1:0] xa0_r, xa1_r, xb0_r, xb1_r, xc0_r, xc1_r;
  logic signed [P-1:0] sax_r, say_r, sbx_r, sby_r, scx_r, scy_r;
  logic signed [D-1:0] cby1_r, acy1_r, bay1_r, cbx1_r, acx1_r, bax1_r;

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      ps0_r  <= bax_r * cay_r;
      ps1_r  <= bay_r * cax_r;
      p11_r  <= cby_r * bdx_r;
      p12_r  <= cbx_r * bdy_r;
      p21_r  <= acy_r * cdx_r;
      p22_r  <= acx_r * cdy_r;
      p31_r  <= bay_r * adx_r;
      p32_r  <= bax_r * ady_r;
      qax_r  <= adx_r * adx_r;
      qay_r  <= ady_r * ady_r;
      qbx_r  <= bdx_r * bdx_r;
      qby_r  <= bdy_r * bdy_r;
      qcx_r  <= cdx_r * cdx_r;
      qcy_r  <= cdy_r * cdy_r;
      xa0_r  <= bdx_r * cdy_r;
      xa1_r  <= bdy_r * cdx_r;
      xb0_r  <= cdx_r * ady_r;
      xb1_r  <= cdy_r * adx_r;
      xc0_r  <= adx_r * bdy_r;
      xc1_r  <= ady_r * bdx_r;
      sax_r  <= ax_r * ax_r;
      say_r  <= ay_r * ay_r;
      sbx_r  <= bx_r * bx_r;
      sby_r  <= by_r * by_r;
      scx_r  <= cx_r * cx_r;
      scy_r  <= cy_r * cy_r;
      cby1_r <= cby_r;
      acy1_r <= acy_r;
      bay1_r <= bay_r;
      cbx1_r <= cbx_r;
      acx1_r <= acx_r;
      bax1_r <= bax_r;
    end
  end

  // stage 2: areas, lifted squares, crosses, vertex norms
  logic signed [Q-1:0] s_r, s1_r, s2_r, s3_r, al_r, bl_r, cl_r, x1_r, x2_r, x3_r;
  logic signed [Q-1:0] sa_r, sb_r, sc_r;
  logic signed [D-1:0] cby2_r, acy2_r, bay2_r, cbx2_r, acx2_r, bax2_r;

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      s_r    <= Q'(ps0_r) - Q'(ps1_r);
      s1_r   <= Q'(p11_r) - Q'(p12_r);
      s2_r   <= Q'(p21_r) - Q'(p22_r);
      s3_r   <= Q'(p31_r) - Q'(p32_r);
      al_r   <= Q'(qax_r) + Q'(qay_r);
      bl_r   <= Q'(qbx_r) + Q'(qby_r);
      cl_r   <= Q'(qcx_r) + Q'(qcy_r);
      x1_r   <= Q'(xa0_r) - Q'(xa1_r);
      x2_r   <= Q'(xb0_r) - Q'(xb1_r);
      x3_r   <= Q'(xc0_r) - Q'(xc1_r);
      sa_r   <= Q'(sax_r) + Q'(say_r);
      sb_r   <= Q'(sbx_r) + Q'(sby_r);
      sc_r   <= Q'(scx_r) + Q'(scy_r);
      cby2_r <= cby1_r;
      acy2_r <= acy1_r;
      bay2_r <= bay1_r;
      cbx2_r <= cbx1_r;
      acx2_r <= acx1_r;
      bax2_r <= bax1_r;
    end
  end

  // stage 3: wide products, containment
  logic signed [MW-1:0]  m1_r, m2_r, m3_r;
  logic signed [NPW-1:0] n1_r, n2_r, n3_r, o1_r, o2_r, o3_r;
  logic signed [Q-1:0]   s3s_r;
  logic                  in_tri3_r;
  logic                  in_tri_nxt;

  always_comb begin
    // a degenerate triangle counts as counter-clockwise here
    if (s_r[Q-1]) begin
      in_tri_nxt = !((!s1_r[Q-1] && |s1_r) || (!s2_r[Q-1] && |s2_r) ||
                     (!s3_r[Q-1] && |s3_r));
    end else begin
      in_tri_nxt = !(s1_r[Q-1] || s2_r[Q-1] || s3_r[Q-1]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      m1_r      <= al_r * x1_r;
      m2_r      <= bl_r * x2_r;
      m3_r      <= cl_r * x3_r;
      n1_r      <= sa_r * cby2_r;
      n2_r      <= sb_r * acy2_r;
      n3_r      <= sc_r * bay2_r;
      o1_r      <= sa_r * cbx2_r;
      o2_r      <= sb_r * acx2_r;
      o3_r      <= sc_r * bax2_r;
      s3s_r     <= s_r;
      in_tri3_r <= in_tri_nxt;
    end
  end

  // stage 4: determinant and center numerators
  logic signed [DW-1:0] det;
  logic signed [NW-1:0] nx_r, ny_r;
  logic signed [Q-1:0]  s4_r;
  logic                 in_tri4_r, in_circ4_r;

  assign det = DW'(m1_r) + DW'(m2_r) + DW'(m3_r);

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      nx_r       <= -(NW'(n1_r) + NW'(n2_r) + NW'(n3_r));
      ny_r       <= NW'(o1_r) + NW'(o2_r) + NW'(o3_r);
      s4_r       <= s3s_r;
      in_tri4_r  <= in_tri3_r;
      // clockwise triangle flips the sign of the determinant
      in_circ4_r <= s3s_r[Q-1] ? det[DW-1] : (!det[DW-1] && |det);
    end
  end

  // stage 5: magnitudes, signs, area clamp
  logic [NW-1:0]         nx_mag, ny_mag;
  logic [Q-1:0]          s_mag;
  logic signed [AXW-1:0] s_ext;
  logic signed [33:0]    area_nxt;
  logic [RW-1:0]         numx_r, numy_r;
  logic [DDW-1:0]        den_r;
  side_t                 side5_r;

  always_comb begin
    nx_mag = nx_r[NW-1] ? NW'(-nx_r) : NW'(nx_r);
    ny_mag = ny_r[NW-1] ? NW'(-ny_r) : NW'(ny_r);
    s_mag  = s4_r[Q-1] ? Q'(-s4_r) : Q'(s4_r);
    s_ext  = AXW'(s4_r);
    if (s_ext > AMAX) begin
      area_nxt = 34'(AMAX);
    end else if (s_ext < AMIN) begin
      area_nxt = 34'(AMIN);
    end else begin
      area_nxt = 34'(s_ext);
    end
  end

  always_ff @(posedge clk) begin
    if (adv[5]) begin
      numx_r          <= RW'(nx_mag) << FRAC_BITS;
      numy_r          <= RW'(ny_mag) << FRAC_BITS;
      den_r           <= {s_mag, 1'b0};
      side5_r.area    <= area_nxt;
      side5_r.in_tri  <= in_tri4_r;
      side5_r.in_circ <= in_circ4_r;
      side5_r.zero    <= ~|s4_r;
      side5_r.neg_x   <= nx_r[NW-1] ^ s4_r[Q-1];
      side5_r.neg_y   <= ny_r[NW-1] ^ s4_r[Q-1];
    end
  end

  // dividers, with the side data riding alongside
  logic [QUO_BITS:0]   div_adv;
  logic [QUO_BITS-1:0] qx, qy;
  logic                ovf_x, ovf_y;
  side_t               side_r [0:QUO_BITS];

  assign div_adv = adv[DIV0 +: QUO_BITS + 1];

  tgp_div #(.RW(RW), .DDW(DDW)) u_div_x (
    .clk (clk),
    .adv (div_adv),
    .num (numx_r),
    .den (den_r),
    .quo (qx),
    .ovf (ovf_x)
  );

  tgp_div #(.RW(RW), .DDW(DDW)) u_div_y (
    .clk (clk),
    .adv (div_adv),
    .num (numy_r),
    .den (den_r),
    .quo (qy),
    .ovf (ovf_y)
  );

  always_ff @(posedge clk) begin
    if (div_adv[0]) begin
      side_r[0] <= side5_r;
    end
    for (int j = 1; j <= QUO_BITS; j++) begin
      if (div_adv[j]) begin
        side_r[j] <= side_r[j-1];
      end
    end
  end

  // output stage: clamp, sign, zero-area override
  side_t               sd;
  logic [QUO_BITS-1:0] lim_x, lim_y, qvx, qvy;
  logic                sat_x, sat_y;
  out_word_t           out_nxt;
  out_word_t           out_word_r;

  always_comb begin
    sd    = side_r[QUO_BITS];
    lim_x = sd.neg_x ? LIM_NEG : LIM_POS;
    lim_y = sd.neg_y ? LIM_NEG : LIM_POS;
    sat_x = ovf_x || (qx > lim_x);
    sat_y = ovf_y || (qy > lim_y);
    qvx   = sat_x ? lim_x : qx;
    qvy   = sat_y ? lim_y : qy;
    out_nxt.area_twice      = sd.area;
    out_nxt.inside_triangle = sd.in_tri;
    out_nxt.inside_circle   = sd.in_circ;
    if (sd.zero) begin
      out_nxt.center_x         = '0;
      out_nxt.center_y         = '0;
      out_nxt.center_valid     = 1'b0;
      out_nxt.center_saturated = 1'b0;
    end else begin
      out_nxt.center_x         = sd.neg_x ? 32'(-qvx) : 32'(qvx);
      out_nxt.center_y         = sd.neg_y ? 32'(-qvy) : 32'(qvy);
      out_nxt.center_valid     = 1'b1;
      out_nxt.center_saturated = sat_x || sat_y;
    end
  end

  always_ff @(posedge clk) begin
    if (adv[NPIPE-1]) begin
      out_word_r <= out_nxt;
    end
  end

  assign out_word = out_word_r;

endmodule

@@ tb/tb_triangle_geometry_predicates_top.sv @@
// tb_triangle_geometry_predicates_top: self-checking bench for the triangle predicates block
// depends on tgp_pkg and triangle_geometry_predicates_top; exact predictor in a scoreboard class
`timescale 1ns / 1ps

module tb_triangle_geometry_predicates_top;
  import tgp_pkg::*;

  localparam int FRAC       = FRAC_BITS_DEF;
  localparam int IDLE_PCT   = 21;
  localparam int RAND_WORDS = 1500;
  localparam int HANG_LIMIT = 5000;
  localparam int DRAIN_CYC  = 100;

  class geometry_scoreboard;
    out_word_t pending[$];
    int        errors = 0;

    static function automatic longint twice_area(longint ax, longint ay, longint bx,
                                                 longint by, longint cx, longint cy);
      return (ax * by - bx * ay) + (bx * cy - cx * by) + (cx * ay - ax * cy);
    endfunction

    // num * 2^FRAC / den truncated toward zero, clamped to 32 bits
    static function automatic logic [31:0] center_coord(logic signed [127:0] num,
                                                        longint den, inout bit sat);
      logic [127:0] n, d, q, lim;
      bit neg;
      neg = (num < 0) != (den < 0);
      n = (num < 0) ? -num : num;
      n = n << FRAC;
      d = (den < 0) ? -den : den;
      q = n / d;
      lim = neg ? 128'h8000_0000 : 128'h7fff_ffff;
      if (q > lim) begin
        sat = 1'b1;
        q = lim;
      end
      return neg ? -q[31:0] : q[31:0];
    endfunction

    static function automatic out_word_t predict_predicates(in_word_t w);
      out_word_t r;
      longint ax, ay, bx, by, cx, cy, tx, ty, s, s1, s2, s3;
      longint adx, ady, bdx, bdy, cdx, cdy;
      logic signed [127:0] p, q, det, nx, ny;
      bit sat;
      ax = w.a_x; ay = w.a_y; bx = w.b_x; by = w.b_y;
      cx = w.c_x; cy = w.c_y; tx = w.test_x; ty = w.test_y;
      s  = twice_area(ax, ay, bx, by, cx, cy);
      s1 = twice_area(bx, by, cx, cy, tx, ty);
      s2 = twice_area(cx, cy, ax, ay, tx, ty);
      s3 = twice_area(ax, ay, bx, by, tx, ty);
      r = '0;
      r.area_twice = s[33:0];
      if (s < 0) r.inside_triangle = !(s1 > 0 || s2 > 0 || s3 > 0);
      else r.inside_triangle = !(s1 < 0 || s2 < 0 || s3 < 0);
      adx = ax - tx; ady = ay - ty; bdx = bx - tx; bdy = by - ty;
      cdx = cx - tx; cdy = cy - ty;
      p = adx * adx + ady * ady; q = bdx * cdy - bdy * cdx; det = p * q;
      p = bdx * bdx + bdy * bdy; q = cdx * ady - cdy * adx; det = det + p * q;
      p = cdx * cdx + cdy * cdy; q = adx * bdy - ady * bdx; det = det + p * q;
      // clockwise triangle flips the sign of the lifted determinant
      r.inside_circle = (s < 0) ? (det < 0) : (det > 0);
      if (s != 0) begin
        p = ax * ax + ay * ay; q = by - cy; nx = p * q;
        q = cx - bx; ny = p * q;
        p = bx * bx + by * by; q = cy - ay; nx = nx + p * q;
        q = ax - cx; ny = ny + p * q;
        p = cx * cx + cy * cy; q = ay - by; nx = nx + p * q;
        q = bx - ax; ny = ny + p * q;
        sat = 1'b0;
        r.center_x = center_coord(nx, 2 * s, sat);
        r.center_y = center_coord(ny, 2 * s, sat);
        r.center_valid = 1'b1;
        r.center_saturated = sat;
      end
      return r;
    endfunction

    function void note_query(in_word_t w);
      pending.push_back(predict_predicates(w));
    endfunction

    function void check_result(out_word_t got);
      out_word_t exp;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result word %h", $time, got);
        errors++;
        return;
      end
      exp = pending.pop_front();
      if (got.area_twice !== exp.area_twice) begin
        $display("%0t: area_twice exp %0d got %0d", $time, exp.area_twice, got.area_twice);
        errors++;
      end
      if (got.inside_triangle !== exp.inside_triangle) begin
        $display("%0t: inside_triangle exp %b got %b", $time, exp.inside_triangle,
                 got.inside_triangle);
        errors++;
      end
      if (got.inside_circle !== exp.inside_circle) begin
        $display("%0t: inside_circle exp %b got %b", $time, exp.inside_circle,
                 got.inside_circle);
        errors++;
      end
      if (got.center_x !== exp.center_x) begin
        $display("%0t: center_x exp %0d got %0d", $time, exp.center_x, got.center_x);
        errors++;
      end
      if (got.center_y !== exp.center_y) begin
        $display("%0t: center_y exp %0d got %0d", $time, exp.center_y, got.center_y);
        errors++;
      end
      if (got.center_valid !== exp.center_valid) begin
        $display("%0t: center_valid exp %b got %b", $time, exp.center_valid,
                 got.center_valid);
        errors++;
      end
      if (got.center_saturated !== exp.center_saturated) begin
        $display("%0t: center_saturated exp %b got %b", $time, exp.center_saturated,
                 got.center_saturated);
        errors++;
      end
    endfunction
  endclass

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_word_t  in_word = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_word_t out_word;

  geometry_scoreboard sb = new();
  bit no_idle = 1'b0;
  int hang_cnt = 0;

  always #2 clk = ~clk;

  triangle_geometry_predicates_top DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
    .out_valid(out_valid), .out_stall(out_stall), .out_word(out_word)
  );

  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) sb.note_query(in_word);
    if (rst_n && out_valid && !out_stall) sb.check_result(out_word);
  end

  always @(posedge clk) begin
    if (rst_n) out_stall <= no_idle ? 1'b0 : ($urandom_range(0, 99) < IDLE_PCT);
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) hang_cnt <= 0;
    else if (rst_n) hang_cnt <= hang_cnt + 1;
    if (hang_cnt >= HANG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic send_query(in_word_t w);
    while (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_tri(int ax, int ay, int bx, int by, int cx, int cy, int tx, int ty);
    in_word_t w;
    w.a_x = 16'(ax); w.a_y = 16'(ay); w.b_x = 16'(bx); w.b_y = 16'(by);
    w.c_x = 16'(cx); w.c_y = 16'(cy); w.test_x = 16'(tx); w.test_y = 16'(ty);
    send_query(w);
  endtask

  function automatic logic [15:0] pick_coord(int mode);
    case (mode)
      0: return 16'($urandom());
      1: return 16'($signed($urandom_range(0, 40)) - 20);
      default: return 16'($signed($urandom_range(0, 2000)) - 1000);
    endcase
  endfunction

  initial begin
    in_word_t w;
    int mode, k;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // extremes, orientation, degenerate and boundary cases
    send_tri(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768);
    send_tri(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767);
    send_tri(-32768, -32768, 32767, -32768, -32768, 32767, 0, 0);
    send_tri(-32768, -32768, -32768, 32767, 32767, -32768, 0, 0);
    send_tri(-32768, 32767, 32767, -32768, 32767, 32767, -32768, -32768);
    send_tri(0, 0, 10, 0, 0, 10, 2, 2);
    send_tri(0, 0, 0, 10, 10, 0, 2, 2);
    send_tri(0, 0, 10, 0, 0, 10, 5, 5);
    send_tri(0, 0, 10, 0, 0, 10, 0, 0);
    send_tri(0, 0, 10, 0, 0, 10, 20, 20);
    send_tri(0, 0, 10, 0, 0, 10, 10, 10);
    send_tri(0, 0, 10, 0, 0, 10, -1, 5);
    send_tri(0, 0, 5, 5, 10, 10, 3, 3);
    send_tri(0, 0, 5, 5, 10, 10, 3, 4);
    send_tri(1, 1, 1, 1, 1, 1, 1, 1);
    send_tri(-32768, -32768, 32767, 32767, 32767, 32766, 0, 0);
    send_tri(-32768, -32768, 32767, 32767, 32766, 32767, 1, 1);
    send_tri(-32768, 0, 32767, 1, 0, 0, 100, 100);
    send_tri(3, 7, -5, 2, 9, -4, 1, 1);
    send_tri(-32768, 32767, 32767, -32768, -32767, 32767, 32767, 32767);
    for (k = 0; k < RAND_WORDS; k++) begin
      no_idle = (k >= 600 && k < 900);
      mode = $urandom_range(0, 2);
      w.a_x = pick_coord(mode); w.a_y = pick_coord(mode);
      w.b_x = pick_coord(mode); w.b_y = pick_coord(mode);
      w.c_x = pick_coord(mode); w.c_y = pick_coord(mode);
      w.test_x = pick_coord(mode); w.test_y = pick_coord(mode);
      // nearly collinear large triangles push the center out of range
      if ($urandom_range(0, 9) == 0) begin
        w.c_x = w.a_x + (w.b_x - w.a_x) + 16'($urandom_range(0, 2));
        w.c_y = w.a_y + (w.b_y - w.a_y) + 16'($urandom_range(0, 2));
      end
      if ($urandom_range(0, 19) == 0) w.test_x = w.a_x;
      send_query(w);
    end
    no_idle = 1'b0;
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
    if (sb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
